>>> sv/assert_macros.svh
// Assertion macros shared by the predictor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle property, checked out of reset.
`define SVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/svp_pkg.sv
// Shared types and constants of the stride value predictor.
package svp_pkg;

  localparam int DATA_W   = 64;
  localparam int TAG_W    = 62;
  localparam int INFL_W   = 16;
  localparam int PC_SHIFT = 2;
  localparam logic [INFL_W-1:0] INFL_MAX = '1;

  typedef enum logic [2:0] {
    FN_PREDICT = 3'd0,
    FN_ALLOC   = 3'd1,
    FN_WRITE   = 3'd2,
    FN_RETIRE  = 3'd3,
    FN_RESTORE = 3'd4,
    FN_SQUASH  = 3'd5,
    FN_QUERY   = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_TAG_BITS = 2'd1,
    CFG_MAX_CONF = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC,
    ST_PRED_CHK,
    ST_PRED_ADD,
    ST_RET_Q,
    ST_RET_T,
    ST_RET_HIT,
    ST_RET_WALK,
    ST_RET_MISS,
    ST_RST_Q,
    ST_RST_T,
    ST_RST_W,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [3:0]        conf;
    logic [DATA_W-1:0] last;
    logic [DATA_W-1:0] stride;
  } tbl_entry_t;

endpackage

>>> sv/svp_req_if.sv
// Request channel of the predictor: valid/ready plus request payload.
interface svp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] pc;
  logic [5:0]  queue_index;
  logic [63:0] value;
  logic        restore_phase;
  logic [6:0]  bundle_count;

  modport source (
    output valid, func, pc, queue_index, value, restore_phase, bundle_count,
    input  ready
  );
  modport sink (
    input  valid, func, pc, queue_index, value, restore_phase, bundle_count,
    output ready
  );
endinterface

>>> sv/svp_rsp_if.sv
// Response channel of the predictor: valid/ready plus response payload.
interface svp_rsp_if;
  logic        valid;
  logic        ready;
  logic        pred_available;
  logic        pred_confident;
  logic [63:0] predicted_value;
  logic [5:0]  alloc_index;
  logic [5:0]  tail_now;
  logic        tail_phase_now;
  logic [6:0]  free_entries;
  logic        must_stall;
  logic        error;

  modport source (
    output valid, pred_available, pred_confident, predicted_value, alloc_index,
           tail_now, tail_phase_now, free_entries, must_stall, error,
    input  ready
  );
  modport sink (
    input  valid, pred_available, pred_confident, predicted_value, alloc_index,
           tail_now, tail_phase_now, free_entries, must_stall, error,
    output ready
  );
endinterface

>>> sv/stride_value_predictor_with_queue.sv
// Stride value predictor: PC-indexed stride table plus in-flight prediction queue.
// One request at a time runs under a small sequencer over a single-port table
// memory and a queue memory. A retire that misses walks the queue once more to
// recount in-flight instances. Restore walks from the restore point to the tail,
// passing over empty slots and doing a table read-modify-write for each live one.
// Squash clears every in-flight count, one table row per cycle. After reset the
// block runs a clearing pass over the table before it takes its first request;
// configuration writes are taken anytime.
`include "assert_macros.svh"

module stride_value_predictor_with_queue #(
  parameter int INDEX_BITS  = 10,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  svp_req_if.sink    in_req,
  svp_rsp_if.source  out_rsp,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);
  import svp_pkg::*;

  localparam int TABLE_SIZE = 1 << INDEX_BITS;
  localparam int AW         = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int QB         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RW         = QB + 2;
  localparam int TAG_FULL   = TAG_W - INDEX_BITS;
  localparam logic [RW-1:0] RING   = RW'(2 * QUEUE_DEPTH);
  localparam logic [RW-1:0] QD_R   = RW'(QUEUE_DEPTH);
  localparam logic [QB-1:0] Q_LAST = QB'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0] T_LAST = AW'(TABLE_SIZE - 1);
  localparam logic [63:0] IDX_MASK = (64'd1 << INDEX_BITS) - 64'd1;

  function automatic logic [AW-1:0] idx_of(input logic [63:0] p);
    idx_of = AW'((p >> PC_SHIFT) & IDX_MASK);
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [63:0] p, input logic [5:0] tb);
    logic [63:0] raw;
    logic [63:0] msk;
    raw = p >> (PC_SHIFT + INDEX_BITS);
    msk = (64'd1 << tb) - 64'd1;
    if (tb == 6'd0) tag_of = '0;
    else if (32'(tb) >= TAG_FULL) tag_of = TAG_W'(raw);
    else tag_of = TAG_W'(raw & msk);
  endfunction

  // position on the ring of 2*depth (index, phase) pairs
  function automatic logic [RW-1:0] ring_pos(input logic [QB-1:0] i, input logic ph);
    ring_pos = ph ? (RW'(i) + QD_R) : RW'(i);
  endfunction

  function automatic logic [RW-1:0] ring_dist(input logic [RW-1:0] a, input logic [RW-1:0] b);
    logic [RW-1:0] d;
    d = b + RING - a;
    if (d >= RING) d = d - RING;
    ring_dist = d;
  endfunction

  function automatic logic [QB-1:0] adv(input logic [QB-1:0] i);
    adv = (i == Q_LAST) ? '0 : i + QB'(1);
  endfunction

  // configuration
  logic             cfg_en_r;
  logic [5:0]       cfg_tb_r;
  logic [3:0]       cfg_mc_r;

  // sequencer
  state_t           state_r, state_nxt;
  logic             sweep_all_r, sweep_all_nxt;
  logic [AW-1:0]    sweep_ctr_r, sweep_ctr_nxt;

  // latched request
  logic [2:0]       req_func_r, req_func_nxt;
  logic [63:0]      req_pc_r, req_pc_nxt;
  logic [5:0]       req_qi_r, req_qi_nxt;
  logic [63:0]      req_value_r, req_value_nxt;
  logic             req_rph_r, req_rph_nxt;
  logic [6:0]       req_bundle_r, req_bundle_nxt;

  // queue control
  logic [QB-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic             head_ph_r, head_ph_nxt, tail_ph_r, tail_ph_nxt;
  logic [QUEUE_DEPTH-1:0] qvalid_r, qvalid_nxt, qvv_r, qvv_nxt;

  // work registers
  logic [63:0]      rpc_r, rpc_nxt, rval_r, rval_nxt;
  logic [63:0]      mul_r, mul_nxt, diff_r, diff_nxt;
  logic [INFL_W-1:0] cnt_r, cnt_nxt;
  logic [QB-1:0]    walk_idx_r, walk_idx_nxt;
  logic [RW-1:0]    walk_left_r, walk_left_nxt;
  logic             pv_r, pv_nxt, pqv_r, pqv_nxt;

  // response being built
  logic             res_avail_r, res_avail_nxt, res_conf_r, res_conf_nxt;
  logic [63:0]      res_pred_r, res_pred_nxt;
  logic [QB-1:0]    res_aidx_r, res_aidx_nxt;
  logic             res_err_r, res_err_nxt;

  // output register
  logic             out_valid_r;
  logic             o_avail_r, o_conf_r, o_tph_r, o_stall_r, o_err_r;
  logic [63:0]      o_pred_r;
  logic [5:0]       o_aidx_r, o_tail_r;
  logic [6:0]       o_free_r;

  // memories
  tbl_entry_t       tbl_mem [TABLE_SIZE];
  logic [INFL_W-1:0] inf_mem [TABLE_SIZE];
  logic [63:0]      qpc_mem [QUEUE_DEPTH];
  logic [63:0]      qval_mem [QUEUE_DEPTH];
  tbl_entry_t       rd_tbl, tbl_wdata;
  logic [INFL_W-1:0] rd_inf, inf_wdata, inf_new;
  logic [63:0]      rd_qpc, rd_qval;
  logic             tbl_we, inf_we, q_pc_we, q_val_we;
  logic [AW-1:0]    t_addr;
  logic [QB-1:0]    q_raddr, q_waddr;

  // shared decode
  logic             in_fire, out_load;
  logic [RW-1:0]    used_cnt, free_cnt, hp, tp, rp;
  logic             qi_in_range, retire_ok, restore_ok, hit_now;
  logic [QB-1:0]    qi_idx;
  logic [63:0]      hit_pc;
  logic [TAG_W-1:0] tag_wr;

  assign in_fire  = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_rsp.ready);

  assign hp       = ring_pos(head_r, head_ph_r);
  assign tp       = ring_pos(tail_r, tail_ph_r);
  assign used_cnt = ring_dist(hp, tp);
  assign free_cnt = QD_R - used_cnt;
  assign qi_idx   = QB'(req_qi_r);
  assign rp       = ring_pos(qi_idx, req_rph_r);
  assign qi_in_range = 32'(req_qi_r) < QUEUE_DEPTH;
  assign retire_ok = cfg_en_r && (used_cnt != '0) && (32'(req_qi_r) == 32'(head_r)) &&
                     qvalid_r[head_r] && qvv_r[head_r];
  assign restore_ok = qi_in_range && !(ring_dist(hp, rp) > ring_dist(hp, tp));

  assign hit_pc  = (state_r == ST_PRED_CHK) ? req_pc_r : rpc_r;
  assign hit_now = (cfg_tb_r == 6'd0) ||
                   (rd_tbl.valid && (rd_tbl.tag == tag_of(hit_pc, cfg_tb_r)));
  assign tag_wr  = tag_of(rpc_r, cfg_tb_r);
  assign inf_new = (rd_inf < INFL_MAX) ? rd_inf + INFL_W'(1) : rd_inf;

  always_comb begin
    unique case (state_r)
      ST_PRED_CHK, ST_PRED_ADD: t_addr = idx_of(req_pc_r);
      ST_RET_Q, ST_RST_T:       t_addr = idx_of(rd_qpc);
      ST_RET_T, ST_RET_HIT, ST_RET_WALK, ST_RET_MISS, ST_RST_W: t_addr = idx_of(rpc_r);
      ST_SWEEP:                 t_addr = sweep_ctr_r;
      default:                  t_addr = idx_of(req_pc_r);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (sweep_ctr_r == T_LAST) state_nxt = sweep_all_r ? ST_IDLE : ST_RESP;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (req_func_r)
          FN_PREDICT: state_nxt = cfg_en_r ? ST_PRED_CHK : ST_RESP;
          FN_RETIRE:  state_nxt = retire_ok ? ST_RET_Q : ST_RESP;
          FN_RESTORE: state_nxt = (cfg_en_r && restore_ok) ? ST_RST_Q : ST_RESP;
          FN_SQUASH:  state_nxt = cfg_en_r ? ST_SWEEP : ST_RESP;
          default:    state_nxt = ST_RESP;
        endcase
      end
      ST_PRED_CHK: state_nxt = hit_now ? ST_PRED_ADD : ST_RESP;
      ST_PRED_ADD: state_nxt = ST_RESP;
      ST_RET_Q:    state_nxt = ST_RET_T;
      ST_RET_T: begin
        if (hit_now) state_nxt = (rd_inf == '0) ? ST_RESP : ST_RET_HIT;
        else state_nxt = ST_RET_WALK;
      end
      ST_RET_HIT:  state_nxt = ST_RESP;
      ST_RET_WALK: begin
        if (walk_left_r == '0 && !pv_r) state_nxt = ST_RET_MISS;
      end
      ST_RET_MISS: state_nxt = ST_RESP;
      ST_RST_Q: begin
        if (walk_left_r == '0) state_nxt = ST_RESP;
        else if (qvalid_r[walk_idx_r]) state_nxt = ST_RST_T;
      end
      ST_RST_T:    state_nxt = ST_RST_W;
      ST_RST_W:    state_nxt = ST_RST_Q;
      ST_RESP: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    sweep_all_nxt = sweep_all_r;
    sweep_ctr_nxt = sweep_ctr_r;
    req_func_nxt = req_func_r;   req_pc_nxt = req_pc_r;     req_qi_nxt = req_qi_r;
    req_value_nxt = req_value_r; req_rph_nxt = req_rph_r;   req_bundle_nxt = req_bundle_r;
    head_nxt = head_r;  head_ph_nxt = head_ph_r;
    tail_nxt = tail_r;  tail_ph_nxt = tail_ph_r;
    qvalid_nxt = qvalid_r;  qvv_nxt = qvv_r;
    rpc_nxt = rpc_r;  rval_nxt = rval_r;  mul_nxt = mul_r;  diff_nxt = diff_r;
    cnt_nxt = cnt_r;  walk_idx_nxt = walk_idx_r;  walk_left_nxt = walk_left_r;
    pv_nxt = pv_r;  pqv_nxt = pqv_r;
    res_avail_nxt = res_avail_r;  res_conf_nxt = res_conf_r;  res_pred_nxt = res_pred_r;
    res_aidx_nxt = res_aidx_r;    res_err_nxt = res_err_r;
    tbl_we = 1'b0;  inf_we = 1'b0;  q_pc_we = 1'b0;  q_val_we = 1'b0;
    tbl_wdata = '0;  inf_wdata = '0;
    q_raddr = head_r;  q_waddr = tail_r;

    unique case (state_r)
      ST_SWEEP: begin
        inf_we = 1'b1;
        tbl_we = sweep_all_r;
        if (sweep_ctr_r == T_LAST) begin
          sweep_ctr_nxt = '0;
          sweep_all_nxt = 1'b0;
        end else begin
          sweep_ctr_nxt = sweep_ctr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_func_nxt = in_req.func;        req_pc_nxt = in_req.pc;
          req_qi_nxt = in_req.queue_index;   req_value_nxt = in_req.value;
          req_rph_nxt = in_req.restore_phase; req_bundle_nxt = in_req.bundle_count;
          res_avail_nxt = 1'b0;  res_conf_nxt = 1'b0;  res_pred_nxt = '0;
          res_aidx_nxt = '0;     res_err_nxt = 1'b0;
        end
      end
      ST_EXEC: begin
        case (req_func_r)
          FN_PREDICT: ;
          FN_ALLOC: begin
            if (!cfg_en_r || used_cnt >= QD_R) begin
              res_err_nxt = 1'b1;
            end else begin
              q_pc_we = 1'b1;
              qvalid_nxt[tail_r] = 1'b1;
              qvv_nxt[tail_r] = 1'b0;
              res_aidx_nxt = tail_r;
              tail_nxt = adv(tail_r);
              if (tail_r == Q_LAST) tail_ph_nxt = ~tail_ph_r;
            end
          end
          FN_WRITE: begin
            if (!qi_in_range || !qvalid_r[qi_idx]) begin
              res_err_nxt = 1'b1;
            end else begin
              q_val_we = 1'b1;
              q_waddr = qi_idx;
              qvv_nxt[qi_idx] = 1'b1;
            end
          end
          FN_RETIRE: begin
            if (!retire_ok) res_err_nxt = 1'b1;
          end
          FN_RESTORE: begin
            if (cfg_en_r) begin
              if (!restore_ok) begin
                res_err_nxt = 1'b1;
              end else begin
                walk_idx_nxt = qi_idx;
                walk_left_nxt = ring_dist(rp, tp);
                tail_nxt = qi_idx;
                tail_ph_nxt = req_rph_r;
              end
            end
          end
          FN_SQUASH: begin
            if (cfg_en_r) begin
              head_nxt = '0;  head_ph_nxt = 1'b0;
              tail_nxt = '0;  tail_ph_nxt = 1'b0;
              qvalid_nxt = '0;  qvv_nxt = '0;
              sweep_all_nxt = 1'b0;
              sweep_ctr_nxt = '0;
            end
          end
          FN_QUERY: ;
          default: res_err_nxt = 1'b1;
        endcase
      end
      ST_PRED_CHK: begin
        if (hit_now) begin
          inf_we = 1'b1;
          inf_wdata = inf_new;
          mul_nxt = 64'(rd_tbl.stride * inf_new);
          res_avail_nxt = 1'b1;
          res_conf_nxt = (rd_tbl.conf == cfg_mc_r);
        end
      end
      ST_PRED_ADD: res_pred_nxt = rd_tbl.last + mul_r;
      ST_RET_Q: begin
        rpc_nxt = rd_qpc;
        rval_nxt = rd_qval;
      end
      ST_RET_T: begin
        if (hit_now && rd_inf == '0) begin
          res_err_nxt = 1'b1;
        end else begin
          qvalid_nxt[head_r] = 1'b0;
          qvv_nxt[head_r] = 1'b0;
          head_nxt = adv(head_r);
          if (head_r == Q_LAST) head_ph_nxt = ~head_ph_r;
          diff_nxt = rval_r - rd_tbl.last;
          // miss: recount live entries behind the new head
          walk_idx_nxt = adv(head_r);
          walk_left_nxt = used_cnt - RW'(1);
          cnt_nxt = '0;
          pv_nxt = 1'b0;
        end
      end
      ST_RET_HIT: begin
        tbl_we = 1'b1;
        tbl_wdata.valid = 1'b1;
        tbl_wdata.tag = tag_wr;
        tbl_wdata.last = rval_r;
        if (diff_r == rd_tbl.stride) begin
          tbl_wdata.stride = rd_tbl.stride;
          tbl_wdata.conf = (rd_tbl.conf < cfg_mc_r) ? rd_tbl.conf + 4'd1 : rd_tbl.conf;
        end else begin
          tbl_wdata.stride = diff_r;
          tbl_wdata.conf = 4'd0;
        end
        inf_we = 1'b1;
        inf_wdata = rd_inf - INFL_W'(1);
      end
      ST_RET_WALK: begin
        q_raddr = walk_idx_r;
        if (pv_r && pqv_r && idx_of(rd_qpc) == idx_of(rpc_r) &&
            tag_of(rd_qpc, cfg_tb_r) == tag_wr) begin
          cnt_nxt = cnt_r + INFL_W'(1);
        end
        pv_nxt = (walk_left_r != '0);
        pqv_nxt = qvalid_r[walk_idx_r];
        if (walk_left_r != '0) begin
          walk_idx_nxt = adv(walk_idx_r);
          walk_left_nxt = walk_left_r - RW'(1);
        end
      end
      ST_RET_MISS: begin
        tbl_we = 1'b1;
        tbl_wdata.valid = 1'b1;
        tbl_wdata.tag = tag_wr;
        tbl_wdata.conf = 4'd0;
        tbl_wdata.last = rval_r;
        tbl_wdata.stride = rval_r;
        inf_we = 1'b1;
        inf_wdata = cnt_r;
      end
      ST_RST_Q: begin
        q_raddr = walk_idx_r;
        if (walk_left_r != '0) begin
          qvalid_nxt[walk_idx_r] = 1'b0;
          qvv_nxt[walk_idx_r] = 1'b0;
          walk_idx_nxt = adv(walk_idx_r);
          walk_left_nxt = walk_left_r - RW'(1);
        end
      end
      ST_RST_T: rpc_nxt = rd_qpc;
      ST_RST_W: begin
        if (hit_now && rd_inf != '0) begin
          inf_we = 1'b1;
          inf_wdata = rd_inf - INFL_W'(1);
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_all_r <= 1'b1;
      sweep_ctr_r <= '0;
      head_r      <= '0;
      head_ph_r   <= 1'b0;
      tail_r      <= '0;
      tail_ph_r   <= 1'b0;
      qvalid_r    <= '0;
      qvv_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_all_r <= sweep_all_nxt;
      sweep_ctr_r <= sweep_ctr_nxt;
      head_r      <= head_nxt;
      head_ph_r   <= head_ph_nxt;
      tail_r      <= tail_nxt;
      tail_ph_r   <= tail_ph_nxt;
      qvalid_r    <= qvalid_nxt;
      qvv_r       <= qvv_nxt;
      pv_r        <= pv_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r <= 1'b1;
      cfg_tb_r <= 6'd8;
      cfg_mc_r <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:   cfg_en_r <= cfg_data[0];
        CFG_TAG_BITS: cfg_tb_r <= cfg_data;
        CFG_MAX_CONF: cfg_mc_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_func_r <= req_func_nxt;   req_pc_r <= req_pc_nxt;     req_qi_r <= req_qi_nxt;
    req_value_r <= req_value_nxt; req_rph_r <= req_rph_nxt;   req_bundle_r <= req_bundle_nxt;
    rpc_r <= rpc_nxt;  rval_r <= rval_nxt;  mul_r <= mul_nxt;  diff_r <= diff_nxt;
    cnt_r <= cnt_nxt;  walk_idx_r <= walk_idx_nxt;  walk_left_r <= walk_left_nxt;
    pqv_r <= pqv_nxt;
    res_avail_r <= res_avail_nxt;  res_conf_r <= res_conf_nxt;  res_pred_r <= res_pred_nxt;
    res_aidx_r <= res_aidx_nxt;    res_err_r <= res_err_nxt;
    if (out_load) begin
      o_avail_r <= res_avail_r;
      o_conf_r  <= res_conf_r;
      o_pred_r  <= res_pred_r;
      o_aidx_r  <= 6'(res_aidx_r);
      o_tail_r  <= 6'(tail_r);
      o_tph_r   <= tail_ph_r;
      o_free_r  <= 7'(free_cnt);
      o_stall_r <= cfg_en_r && (32'(free_cnt) < 32'(req_bundle_r));
      o_err_r   <= res_err_r;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[t_addr] <= tbl_wdata;
    if (inf_we) inf_mem[t_addr] <= inf_wdata;
    rd_tbl <= tbl_mem[t_addr];
    rd_inf <= inf_mem[t_addr];
  end

  // queue memory, registered read
  always_ff @(posedge clk) begin
    if (q_pc_we) qpc_mem[q_waddr] <= req_pc_r;
    if (q_val_we) qval_mem[q_waddr] <= req_value_r;
    rd_qpc  <= qpc_mem[q_raddr];
    rd_qval <= qval_mem[q_raddr];
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.pred_available  = o_avail_r;
  assign out_rsp.pred_confident  = o_conf_r;
  assign out_rsp.predicted_value = o_pred_r;
  assign out_rsp.alloc_index     = o_aidx_r;
  assign out_rsp.tail_now        = o_tail_r;
  assign out_rsp.tail_phase_now  = o_tph_r;
  assign out_rsp.free_entries    = o_free_r;
  assign out_rsp.must_stall      = o_stall_r;
  assign out_rsp.error           = o_err_r;

  `SVP_ASSERT(a_occupancy, used_cnt <= QD_R, "queue occupancy exceeds depth")
  `SVP_ASSERT(a_empty_clean, (state_r == ST_IDLE && used_cnt == '0) |-> (qvalid_r == '0), "live entry in empty queue")
  `SVP_ASSERT(a_value_needs_entry, (qvv_r & ~qvalid_r) == '0, "value flag on dead entry")
  `SVP_ASSERT_NEXT(a_busy_after_accept, in_fire, state_r != ST_IDLE, "sequencer idle after accept")

endmodule
